>>> rtl/core/wbdf_pkg.sv
// ----------------------------------------------------------------------------
// wbdf_pkg
// Shared types, constants and a function of the byte descrambler with
// CRC-32 frame check: item modes, queued operations, the descrambler
// step table and the byte-wise reflected CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package wbdf_pkg;

  // Frame length register width and limits.
  localparam int unsigned FRAME_W = 12;
  localparam logic [FRAME_W-1:0] MIN_FRAME = FRAME_W'(4);
  localparam logic [FRAME_W-1:0] MAX_FRAME = FRAME_W'(4095);
  localparam logic [FRAME_W-1:0] FCS_BYTES = FRAME_W'(4);
  localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(4);

  // CRC-32 constants (reflected form).
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Configuration register byte addresses.
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_FRAME_LENGTH = 3'd0;

  // Input item modes.
  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_ARM   = 2'd1,
    MODE_ABORT = 2'd2
  } mode_t;

  // Front-end frame tracking states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROP,
    ST_SEED,
    ST_DATA
  } front_st_t;

  // Operations handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_ARM,
    OP_SEED,
    OP_DATA
  } op_kind_t;

  typedef struct packed {
    op_kind_t  kind;
    logic [7:0] raw_byte;
    logic       crc_en;
    logic       last;
  } op_t;

  // Scrambler state advanced eight steps, indexed by the upper seven bits.
  localparam logic [7:0] SCR_NEXT [128] = '{
    8'h00, 8'h91, 8'h22, 8'hb3, 8'h44, 8'hd5, 8'h66, 8'hf7,
    8'h19, 8'h88, 8'h3b, 8'haa, 8'h5d, 8'hcc, 8'h7f, 8'hee,
    8'h32, 8'ha3, 8'h10, 8'h81, 8'h76, 8'he7, 8'h54, 8'hc5,
    8'h2b, 8'hba, 8'h09, 8'h98, 8'h6f, 8'hfe, 8'h4d, 8'hdc,
    8'h64, 8'hf5, 8'h46, 8'hd7, 8'h20, 8'hb1, 8'h02, 8'h93,
    8'h7d, 8'hec, 8'h5f, 8'hce, 8'h39, 8'ha8, 8'h1b, 8'h8a,
    8'h56, 8'hc7, 8'h74, 8'he5, 8'h12, 8'h83, 8'h30, 8'ha1,
    8'h4f, 8'hde, 8'h6d, 8'hfc, 8'h0b, 8'h9a, 8'h29, 8'hb8,
    8'hc8, 8'h59, 8'hea, 8'h7b, 8'h8c, 8'h1d, 8'hae, 8'h3f,
    8'hd1, 8'h40, 8'hf3, 8'h62, 8'h95, 8'h04, 8'hb7, 8'h26,
    8'hfa, 8'h6b, 8'hd8, 8'h49, 8'hbe, 8'h2f, 8'h9c, 8'h0d,
    8'he3, 8'h72, 8'hc1, 8'h50, 8'ha7, 8'h36, 8'h85, 8'h14,
    8'hac, 8'h3d, 8'h8e, 8'h1f, 8'he8, 8'h79, 8'hca, 8'h5b,
    8'hb5, 8'h24, 8'h97, 8'h06, 8'hf1, 8'h60, 8'hd3, 8'h42,
    8'h9e, 8'h0f, 8'hbc, 8'h2d, 8'hda, 8'h4b, 8'hf8, 8'h69,
    8'h87, 8'h16, 8'ha5, 8'h34, 8'hc3, 8'h52, 8'he1, 8'h70
  };

  // One byte of the reflected CRC-32, LSB first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/wbdf_ifs.sv
// ----------------------------------------------------------------------------
// wbdf_ifs
// Valid/ready channels of the descrambler: raw byte requests in and
// descrambled byte requests out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbdf_in_if;
  import wbdf_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] raw_byte;

  modport source (output valid, output mode, output raw_byte, input ready);
  modport sink   (input valid, input mode, input raw_byte, output ready);
endinterface

interface wbdf_out_if;
  import wbdf_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last;
  logic        crc_ok;
  logic [31:0] crc_value;

  modport source (output valid, output data_byte, output last, output crc_ok,
                  output crc_value, input ready);
  modport sink   (input valid, input data_byte, input last, input crc_ok,
                  input crc_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wbdf_front.sv
// ----------------------------------------------------------------------------
// wbdf_front
// Front end: accepts every input request while the queue has room, tracks
// where the frame stands (idle, dropped byte, seed byte, data bytes) and
// queues one operation for each request that touches the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wbdf_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  wbdf_in_if.sink                        in_item,
  input  wire logic [wbdf_pkg::FRAME_W-1:0] frame_length,
  output      logic                      push_valid,
  input  wire logic                      push_ready,
  output      wbdf_pkg::op_t             push_op
);
  import wbdf_pkg::*;

  front_st_t          state;
  front_st_t          state_next;
  logic [FRAME_W-1:0] count;
  logic [FRAME_W-1:0] last_pos;
  logic [FRAME_W-1:0] crc_limit;
  logic [FRAME_W-1:0] len_clamped;
  logic               accept;
  logic               is_arm;
  logic               is_abort;
  logic               is_raw;
  logic               data_last;

  // Requests are taken whenever the queue has room, including ignored ones.
  assign in_item.ready = push_ready;
  assign accept        = in_item.valid && push_ready;

  assign is_arm    = (mode_t'(in_item.mode) == MODE_ARM);
  assign is_abort  = (mode_t'(in_item.mode) == MODE_ABORT);
  assign is_raw    = (mode_t'(in_item.mode) == MODE_RAW);
  assign data_last = (count == last_pos);

  // Frame length is clamped into the legal range when a frame is armed.
  always_comb begin
    len_clamped = frame_length;
    if (frame_length < MIN_FRAME) begin
      len_clamped = MIN_FRAME;
    end else if (frame_length > MAX_FRAME) begin
      len_clamped = MAX_FRAME;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    if (accept) begin
      if (is_arm) begin
        state_next = ST_DROP;
      end else if (is_abort) begin
        state_next = ST_IDLE;
      end else if (is_raw) begin
        case (state)
          ST_IDLE: state_next = ST_IDLE;
          ST_DROP: state_next = ST_SEED;
          ST_SEED: state_next = ST_DATA;
          ST_DATA: state_next = data_last ? ST_IDLE : ST_DATA;
          default: state_next = ST_IDLE;
        endcase
      end
    end
  end

  // Queue outputs.
  always_comb begin
    push_valid       = 1'b0;
    push_op.kind     = OP_DATA;
    push_op.raw_byte = in_item.raw_byte;
    push_op.crc_en   = (count < crc_limit);
    push_op.last     = data_last;
    if (in_item.valid) begin
      if (is_arm) begin
        push_valid   = 1'b1;
        push_op.kind = OP_ARM;
      end else if (is_raw) begin
        case (state)
          ST_SEED: begin
            push_valid   = 1'b1;
            push_op.kind = OP_SEED;
          end
          ST_DATA: begin
            push_valid   = 1'b1;
            push_op.kind = OP_DATA;
          end
          default: push_valid = 1'b0;
        endcase
      end
    end
  end

  // Frame state and byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      last_pos  <= FRAME_RESET - FRAME_W'(1);
      crc_limit <= FRAME_RESET - FCS_BYTES;
    end else begin
      state <= state_next;
      if (accept && is_arm) begin
        count     <= '0;
        last_pos  <= len_clamped - FRAME_W'(1);
        crc_limit <= len_clamped - FCS_BYTES;
      end else if (accept && is_raw && state == ST_DATA) begin
        count <= count + FRAME_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wbdf_queue.sv
// ----------------------------------------------------------------------------
// wbdf_queue
// Two-entry operation queue between front and back end, so that each side
// can stall on its own while full rate is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module wbdf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output      logic          push_ready,
  input  wire wbdf_pkg::op_t push_op,
  output      logic          pop_valid,
  input  wire logic          pop_ready,
  output      wbdf_pkg::op_t pop_op
);
  import wbdf_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wbdf_back.sv
// ----------------------------------------------------------------------------
// wbdf_back
// Back end: runs the table-driven byte descrambler and the CRC-32, keeps
// the last four data bytes and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbdf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  output      logic          pop_ready,
  input  wire wbdf_pkg::op_t pop_op,
  wbdf_out_if.source         out_item
);
  import wbdf_pkg::*;

  logic [7:0]  scr_state;
  logic [31:0] crc_reg;
  logic [31:0] tail_bytes;
  logic        out_valid;
  logic [7:0]  data_byte;
  logic        last;
  logic        crc_ok;
  logic [31:0] crc_value;

  logic        do_pop;
  logic [7:0]  data;
  logic [31:0] crc_next;
  logic [31:0] tail_next;

  // An operation is taken when the output register is free or draining.
  assign pop_ready = !out_valid || out_item.ready;
  assign do_pop    = pop_valid && pop_ready;

  // Descramble, CRC and tail window for a data byte.
  assign data      = pop_op.raw_byte ^ scr_state;
  assign crc_next  = pop_op.crc_en ? crc32_byte(crc_reg, data) : crc_reg;
  assign tail_next = {data, tail_bytes[31:8]};

  // Datapath state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_state  <= 8'd0;
      crc_reg    <= CRC_INIT;
      tail_bytes <= 32'd0;
    end else if (do_pop) begin
      case (pop_op.kind)
        OP_ARM: begin
          crc_reg    <= CRC_INIT;
          tail_bytes <= 32'd0;
        end
        OP_SEED: scr_state <= SCR_NEXT[pop_op.raw_byte[7:1]];
        OP_DATA: begin
          scr_state  <= SCR_NEXT[scr_state[7:1]];
          crc_reg    <= crc_next;
          tail_bytes <= tail_next;
        end
        default: scr_state <= scr_state;
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_pop && pop_op.kind == OP_DATA) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (do_pop && pop_op.kind == OP_DATA) begin
      data_byte <= data;
      last      <= pop_op.last;
      crc_ok    <= pop_op.last && (tail_next == ~crc_next);
      crc_value <= ~crc_next;
    end
  end

  assign out_item.valid     = out_valid;
  assign out_item.data_byte = data_byte;
  assign out_item.last      = last;
  assign out_item.crc_ok    = crc_ok;
  assign out_item.crc_value = crc_value;

endmodule

`default_nettype wire

>>> rtl/core/wlan_byte_descrambler_fcs_check.sv
// ----------------------------------------------------------------------------
// wlan_byte_descrambler_fcs_check
// 802.11a byte descrambler with CRC-32 frame check sequence test. Holds
// the frame length register and joins front end, queue and back end.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake       payload
//   in_item   in   valid/ready     mode[1:0], raw_byte[7:0]
//   out_item  out  valid/ready     data_byte[7:0], last, crc_ok, crc_value[31:0]
//   apb       in   psel/penable    paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// One input request is taken every cycle while the queue has room; a data
// byte passes through a queue entry and then the output register.
// The back end updates descrambler and CRC for one byte per cycle unless
// the output stalls; the eight-step CRC byte update sets the clock limit.
// Reset is synchronous and clears frame state, queue and the output valid flag.
// Output stalls fill the two-entry queue, which then holds off input.
// ----------------------------------------------------------------------------
`default_nettype none

module wlan_byte_descrambler_fcs_check (
  input  wire logic                        clk,
  input  wire logic                        rst,
  wbdf_in_if.sink                          in_item,
  wbdf_out_if.source                       out_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wbdf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);
  import wbdf_pkg::*;

  logic [FRAME_W-1:0] frame_length;
  logic               push_valid;
  logic               push_ready;
  op_t                push_op;
  logic               pop_valid;
  logic               pop_ready;
  op_t                pop_op;
  logic               reg_sel;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_FRAME_LENGTH[ADDR_W-1:2]);
  assign prdata  = reg_sel ? {{(32-FRAME_W){1'b0}}, frame_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      frame_length <= pwdata[FRAME_W-1:0];
    end
  end

  // Front end: classify requests.
  wbdf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_item      (in_item),
    .frame_length (frame_length),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_op      (push_op)
  );

  // Operation queue.
  wbdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // Back end: descramble and check.
  wbdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
